>>> rtl/usfp_pkg.sv
// ----------------------------------------------------------------------------
// usfp_pkg: shared types and constants of the UART status frame parser
// Payload structs, frame byte codes, result codes and sizing constants.
// ----------------------------------------------------------------------------
package usfp_pkg;

   // Body bytes after which an open frame is dropped as an overflow
   localparam int unsigned BODY_LIMIT = 200;

   localparam logic [15:0] TIMEOUT_RESET = 16'd500;

   // Frame byte codes
   localparam logic [7:0] BYTE_HEAD0  = 8'hBC;
   localparam logic [7:0] BYTE_HEAD1  = 8'hFD;
   localparam logic [7:0] BYTE_END    = 8'hAE;
   localparam logic [7:0] CMD_STATUS  = 8'h81;
   localparam logic [7:0] VAL_READY   = 8'h01;
   localparam logic [7:0] VAL_NOPAPER = 8'h03;
   localparam logic [7:0] VAL_PRINTED = 8'h04;

   // Input item kinds
   localparam logic MODE_BYTE = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   // Status event codes
   localparam logic [1:0] EVENT_NONE    = 2'd0;
   localparam logic [1:0] EVENT_READY   = 2'd1;
   localparam logic [1:0] EVENT_NOPAPER = 2'd2;
   localparam logic [1:0] EVENT_PRINTED = 2'd3;

   // Abort codes
   localparam logic [1:0] ABORT_NONE     = 2'd0;
   localparam logic [1:0] ABORT_OVERFLOW = 2'd1;
   localparam logic [1:0] ABORT_TIMEOUT  = 2'd2;

   typedef struct packed {
      logic       mode;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic       frame_done;
      logic [7:0] frame_cmd;
      logic [7:0] frame_value;
      logic [1:0] status_event;
      logic [1:0] abort_code;
   } rsp_type;

endpackage

>>> rtl/usfp_parser.sv
// ----------------------------------------------------------------------------
// usfp_parser: frame state machine
// Holds the parse state and works out one result for each accepted item.
// ----------------------------------------------------------------------------
module usfp_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  usfp_pkg::req_type item,
   input  logic [15:0]      timeout_ticks,
   output usfp_pkg::rsp_type result
);
   import usfp_pkg::*;

   typedef enum logic [7:0] {
      PH_HEAD0 = 8'b0000_0001,
      PH_HEAD1 = 8'b0000_0010,
      PH_CMD   = 8'b0000_0100,
      PH_LEN   = 8'b0000_1000,
      PH_DATA  = 8'b0001_0000,
      PH_TRL1  = 8'b0010_0000,
      PH_TRL2  = 8'b0100_0000,
      PH_END   = 8'b1000_0000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  body_count_ff, body_count_in;
   logic [7:0]  bytes_left_ff, bytes_left_in;
   logic [7:0]  held_cmd_ff, held_cmd_in;
   logic [7:0]  held_value_ff, held_value_in;
   logic [16:0] elapsed_ff, elapsed_in;

   logic [7:0]  body_next;
   logic        limit_hit;
   logic [7:0]  left_next;

   assign body_next = body_count_ff + 8'd1;
   assign limit_hit = (body_next >= 8'(BODY_LIMIT));
   assign left_next = bytes_left_ff - 8'd1;

   always_comb begin
      phase_in      = phase_ff;
      body_count_in = body_count_ff;
      bytes_left_in = bytes_left_ff;
      held_cmd_in   = held_cmd_ff;
      held_value_in = held_value_ff;
      elapsed_in    = elapsed_ff;
      result        = '0;

      if (item.mode == MODE_TICK) begin
         if (phase_ff != PH_HEAD0) begin
            elapsed_in = elapsed_ff + 17'd1;
            if (elapsed_in > {1'b0, timeout_ticks}) begin
               phase_in          = PH_HEAD0;
               elapsed_in        = '0;
               result.abort_code = ABORT_TIMEOUT;
            end
         end
      end else begin
         // store a body byte in every phase that counts one
         if (phase_ff == PH_CMD || phase_ff == PH_LEN || phase_ff == PH_DATA ||
             phase_ff == PH_TRL1 || phase_ff == PH_TRL2) begin
            body_count_in = body_next;
            if (body_count_ff == 8'd2) begin
               held_value_in = item.rx_byte;
            end
         end

         unique case (phase_ff)
            PH_HEAD0: begin
               if (item.rx_byte == BYTE_HEAD0) begin
                  body_count_in = '0;
                  elapsed_in    = '0;
                  phase_in      = PH_HEAD1;
               end
            end
            PH_HEAD1: begin
               if (item.rx_byte == BYTE_HEAD1) begin
                  phase_in = PH_CMD;
               end
            end
            PH_CMD: begin
               held_cmd_in   = item.rx_byte;
               bytes_left_in = '0;
               phase_in      = PH_LEN;
            end
            PH_LEN: begin
               bytes_left_in = item.rx_byte;
               phase_in      = (item.rx_byte != 8'd0) ? PH_DATA : PH_TRL1;
            end
            PH_DATA: begin
               if (limit_hit) begin
                  phase_in          = PH_HEAD0;
                  elapsed_in        = '0;
                  result.abort_code = ABORT_OVERFLOW;
               end else begin
                  bytes_left_in = left_next;
                  if (left_next == 8'd0) begin
                     phase_in = PH_TRL1;
                  end
               end
            end
            PH_TRL1, PH_TRL2: begin
               if (limit_hit) begin
                  phase_in          = PH_HEAD0;
                  elapsed_in        = '0;
                  result.abort_code = ABORT_OVERFLOW;
               end else begin
                  phase_in = (phase_ff == PH_TRL1) ? PH_TRL2 : PH_END;
               end
            end
            PH_END: begin
               if (item.rx_byte == BYTE_END) begin
                  result.frame_done  = 1'b1;
                  result.frame_cmd   = held_cmd_ff;
                  result.frame_value = held_value_ff;
                  if (held_cmd_ff == CMD_STATUS) begin
                     case (held_value_ff)
                        VAL_READY:   result.status_event = EVENT_READY;
                        VAL_NOPAPER: result.status_event = EVENT_NOPAPER;
                        VAL_PRINTED: result.status_event = EVENT_PRINTED;
                        default:     result.status_event = EVENT_NONE;
                     endcase
                  end
                  phase_in   = PH_HEAD0;
                  elapsed_in = '0;
               end
            end
            default: begin
               phase_in = PH_HEAD0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEAD0;
         body_count_ff <= '0;
         bytes_left_ff <= '0;
         held_cmd_ff   <= '0;
         held_value_ff <= '0;
         elapsed_ff    <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         body_count_ff <= body_count_in;
         bytes_left_ff <= bytes_left_in;
         held_cmd_ff   <= held_cmd_in;
         held_value_ff <= held_value_in;
         elapsed_ff    <= elapsed_in;
      end
   end

endmodule

>>> rtl/usfp_out_reg.sv
// ----------------------------------------------------------------------------
// usfp_out_reg: result register
// Holds one result until the consumer takes it; frees itself on the take.
// ----------------------------------------------------------------------------
module usfp_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  usfp_pkg::rsp_type result,
   output logic              can_load,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output usfp_pkg::rsp_type rsp_data
);
   import usfp_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   // free when empty or emptied this cycle
   assign can_load = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

>>> rtl/uart_status_frame_parser_top.sv
// ----------------------------------------------------------------------------
// uart_status_frame_parser_top: printer status frame parser
// Parses received UART bytes and time ticks for BC FD status frames.
// ----------------------------------------------------------------------------
// Each request item is one received byte (mode 0) or one time tick (mode 1),
// and each gives exactly one response item, in the cycle after it is accepted.
// An item is taken in every cycle while the response register is empty or
// being emptied, so the block sustains one item per clock; the only limit is
// the single response register, which stalls requests while it holds an item
// and rsp_ready is low.
// Frames are BC FD cmd len data[len] t1 t2 AE. On the AE the response carries
// frame_done, the command and the body byte at offset two, plus a status
// event for command 0x81. Frames that reach the body limit abort with code
// overflow; frames open longer than timeout_ticks ticks abort with timeout.
// The timeout register is written through the csr channel, which is always
// ready; write it only while no request is outstanding.
// ----------------------------------------------------------------------------
module uart_status_frame_parser_top (
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_ready,
   input  usfp_pkg::req_type req_data,

   output logic              rsp_valid,
   input  logic              rsp_ready,
   output usfp_pkg::rsp_type rsp_data,

   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [15:0]       csr_data
);
   import usfp_pkg::*;

   logic [15:0] timeout_ff;
   logic        step;
   logic        can_load;
   rsp_type     result;

   // Timeout register: accept a write in any cycle
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_valid) begin
         timeout_ff <= csr_data;
      end
   end

   // Take a request whenever the response register can hold its result
   assign req_ready = can_load;
   assign step      = req_valid && req_ready;

   usfp_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .item          (req_data),
      .timeout_ticks (timeout_ff),
      .result        (result)
   );

   usfp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (step),
      .result    (result),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> rtl/usfp_checker.sv
// ----------------------------------------------------------------------------
// usfp_checker: port-level checks for the status frame parser
// Watches the top-level ports and flags results or flow control gone wrong.
// ----------------------------------------------------------------------------
module usfp_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  usfp_pkg::rsp_type rsp_data
);
   import usfp_pkg::*;

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed or dropped");

   // every accepted item shows a result in the next cycle
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted item produced no response");

   // no request taken while the result register is stuck
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request accepted over a stalled response");

   a_done_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_done |-> rsp_data.abort_code == ABORT_NONE)
      else $error("completed frame reported with an abort");

   a_event_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status_event != EVENT_NONE
         |-> rsp_data.frame_done && rsp_data.frame_cmd == CMD_STATUS)
      else $error("status event without a completed status frame");

endmodule

bind uart_status_frame_parser_top usfp_checker u_usfp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> bench/uart_status_frame_parser_top_tb.sv
// ----------------------------------------------------------------------------
// uart_status_frame_parser_top_tb: self-checking bench for the status parser
// Streams bytes and ticks into the parser and tracks the frame state in step
// with it. Every response item is compared field by field, in order, with
// the predicted one. Covers the status events, header and end waits, zero
// length bodies, overflow at the body limit and timeouts at several register
// settings. Random idling is applied on both channels.
// ----------------------------------------------------------------------------
module uart_status_frame_parser_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import usfp_pkg::*;

   // Cycles without any handshake before the run is declared hung
   localparam int QUIET_LIMIT = 1000;

   // Parser phases, in the order a well-formed frame passes through them
   typedef enum logic [7:0] {
      SEEK_HEAD0 = 8'b0000_0001,
      SEEK_HEAD1 = 8'b0000_0010,
      TAKE_CMD   = 8'b0000_0100,
      TAKE_LEN   = 8'b0000_1000,
      TAKE_DATA  = 8'b0001_0000,
      TAKE_TRL1  = 8'b0010_0000,
      TAKE_TRL2  = 8'b0100_0000,
      SEEK_END   = 8'b1000_0000
   } parse_phase_type;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data  = '0;

   // Tracked parser state, advanced once per accepted request item
   parse_phase_type parse_phase = SEEK_HEAD0;
   logic [7:0]   body_count    = '0;
   logic [7:0]   data_left     = '0;
   logic [7:0]   kept_cmd      = '0;
   logic [7:0]   kept_value    = '0;
   logic [16:0]  tick_count    = '0;
   logic [15:0]  timeout_limit = TIMEOUT_RESET;

   // Responses predicted for accepted requests, oldest first
   rsp_type frame_reports[$];

   int error_count   = 0;
   int quiet_cycles  = 0;
   int rsp_stall_left = 0;
   bit idling_on     = 1'b1;
   int tick_rate_pct = 0;

   uart_status_frame_parser_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #2 clock = ~clock;

   // -------------------------------------------------------------------------
   // Frame tracking
   // -------------------------------------------------------------------------

   // Count one body byte; keep the byte at offset two; flag the body limit
   function automatic logic take_body_byte(logic [7:0] b);
      if (body_count == 8'd2)
         kept_value = b;
      body_count = body_count + 8'd1;
      return body_count >= BODY_LIMIT;
   endfunction

   function automatic void drop_frame();
      parse_phase = SEEK_HEAD0;
      tick_count  = '0;
   endfunction

   // Advance the tracked state by one item and return the response it gives
   function automatic rsp_type parse_item(req_type item);
      rsp_type    r;
      logic [7:0] b;
      r = '0;
      b = item.rx_byte;
      if (item.mode == MODE_TICK) begin
         // Ticks only age an open frame; the byte field is ignored
         if (parse_phase != SEEK_HEAD0) begin
            tick_count = tick_count + 17'd1;
            if (tick_count > {1'b0, timeout_limit}) begin
               drop_frame();
               r.abort_code = ABORT_TIMEOUT;
            end
         end
      end else begin
         case (parse_phase)
            SEEK_HEAD0: begin
               if (b == BYTE_HEAD0) begin
                  body_count  = '0;
                  tick_count  = '0;
                  parse_phase = SEEK_HEAD1;
               end
            end
            SEEK_HEAD1: begin
               if (b == BYTE_HEAD1)
                  parse_phase = TAKE_CMD;
            end
            TAKE_CMD: begin
               kept_cmd = b;
               void'(take_body_byte(b));
               data_left   = '0;
               parse_phase = TAKE_LEN;
            end
            TAKE_LEN: begin
               void'(take_body_byte(b));
               data_left = b;
               if (b != 8'd0)
                  parse_phase = TAKE_DATA;
               else
                  parse_phase = TAKE_TRL1;
            end
            TAKE_DATA: begin
               // The body limit wins over the end of the data count
               if (take_body_byte(b)) begin
                  drop_frame();
                  r.abort_code = ABORT_OVERFLOW;
               end else begin
                  data_left = data_left - 8'd1;
                  if (data_left == 8'd0)
                     parse_phase = TAKE_TRL1;
               end
            end
            TAKE_TRL1, TAKE_TRL2: begin
               if (take_body_byte(b)) begin
                  drop_frame();
                  r.abort_code = ABORT_OVERFLOW;
               end else if (parse_phase == TAKE_TRL1) begin
                  parse_phase = TAKE_TRL2;
               end else begin
                  parse_phase = SEEK_END;
               end
            end
            default: begin
               if (b == BYTE_END) begin
                  r.frame_done  = 1'b1;
                  r.frame_cmd   = kept_cmd;
                  r.frame_value = kept_value;
                  if (kept_cmd == CMD_STATUS) begin
                     if (kept_value == VAL_READY)
                        r.status_event = EVENT_READY;
                     else if (kept_value == VAL_NOPAPER)
                        r.status_event = EVENT_NOPAPER;
                     else if (kept_value == VAL_PRINTED)
                        r.status_event = EVENT_PRINTED;
                  end
                  drop_frame();
               end
            end
         endcase
      end
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------

   // Offer one item, optionally after an idle burst; predict it on acceptance
   task automatic send_item(input req_type item);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      frame_reports.push_back(parse_item(item));
   endtask

   task automatic send_tick();
      req_type item;
      item.mode    = MODE_TICK;
      item.rx_byte = 8'($urandom);
      send_item(item);
   endtask

   // Send one received byte, preceded by a tick at the current tick rate
   task automatic send_rx(input logic [7:0] b);
      req_type item;
      item.mode    = MODE_BYTE;
      item.rx_byte = b;
      if ($urandom_range(0, 99) < tick_rate_pct)
         send_tick();
      send_item(item);
   endtask

   function automatic logic [7:0] random_other(logic [7:0] avoid);
      logic [7:0] r;
      r = 8'($urandom);
      if (r == avoid)
         r = ~avoid;
      return r;
   endfunction

   // Send one frame; the value lands at body offset two; junk waits for AE
   task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len,
                             input logic [7:0] value, input int end_junk,
                             input bit closed);
      send_rx(BYTE_HEAD0);
      send_rx(BYTE_HEAD1);
      send_rx(cmd);
      send_rx(len);
      for (int j = 0; j < len; j++)
         send_rx((j == 0) ? value : random_other(BYTE_HEAD0));
      send_rx((len == 8'd0) ? value : random_other(BYTE_HEAD0));
      send_rx(random_other(BYTE_HEAD0));
      repeat (end_junk) send_rx(random_other(BYTE_END));
      if (closed)
         send_rx(BYTE_END);
   endtask

   // Mostly well-formed frames with random content, plus noise and frames
   // that never close
   task automatic send_random_frames(input int count);
      logic [7:0] cmd;
      logic [7:0] len;
      logic [7:0] value;
      for (int i = 0; i < count; i++) begin
         repeat ($urandom_range(0, 2)) send_rx(8'($urandom));
         // open a frame with junk in the wait for FD; send_frame's BC is dropped
         if ($urandom_range(0, 9) == 0) begin
            send_rx(BYTE_HEAD0);
            send_rx(random_other(BYTE_HEAD1));
         end
         cmd = ($urandom_range(0, 1) == 1) ? CMD_STATUS : 8'($urandom);
         len = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(7, 40))
                                            : 8'($urandom_range(0, 6));
         case ($urandom_range(0, 4))
            0:       value = VAL_READY;
            1:       value = VAL_NOPAPER;
            2:       value = VAL_PRINTED;
            default: value = 8'($urandom);
         endcase
         send_frame(cmd, len, value,
                    ($urandom_range(0, 4) == 0) ? int'($urandom_range(1, 3)) : 0,
                    $urandom_range(0, 11) != 0);
      end
   endtask

   // Write the timeout register once the parser has gone quiet
   task automatic set_timeout(input logic [15:0] ticks);
      req_valid <= 1'b0;
      while (frame_reports.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= ticks;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      timeout_limit = ticks;
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Status events, header waits, zero length and idle ticks at reset timeout
   task automatic test_directed_frames();
      tick_rate_pct = 0;
      // drop noise and an idle tick while no frame is open
      send_rx(8'h00); send_rx(8'hFF); send_tick(); send_rx(BYTE_END);
      // ready: junk in the FD wait, zero length, junk in the AE wait
      send_rx(BYTE_HEAD0); send_rx(8'h55); send_rx(BYTE_HEAD1);
      send_rx(CMD_STATUS); send_rx(8'h00); send_rx(VAL_READY); send_rx(8'hFF);
      send_rx(8'h12); send_rx(BYTE_END);
      // out of paper, with a tick inside the frame
      send_rx(BYTE_HEAD0); send_rx(BYTE_HEAD1); send_rx(CMD_STATUS);
      send_rx(8'h01); send_rx(VAL_NOPAPER); send_tick(); send_rx(8'h00);
      send_rx(8'hFF); send_rx(BYTE_END);
      // print finished over two data bytes
      send_rx(BYTE_HEAD0); send_rx(BYTE_HEAD1); send_rx(CMD_STATUS);
      send_rx(8'h02); send_rx(VAL_PRINTED); send_rx(8'hAA); send_rx(8'h55);
      send_rx(8'h00); send_rx(BYTE_END);
   endtask

   // Shortest timeout: one tick survives, the second aborts
   task automatic test_timeout_edges();
      set_timeout(16'd1);
      tick_rate_pct = 0;
      send_rx(BYTE_HEAD0); send_tick(); send_tick();
      send_rx(BYTE_HEAD0); send_rx(BYTE_HEAD1); send_tick();
      send_rx(CMD_STATUS); send_rx(8'h00); send_rx(VAL_READY);
      send_rx(8'h00); send_rx(BYTE_END);
      tick_rate_pct = 25;
      send_random_frames(4);
   endtask

   task automatic test_random_frames();
      set_timeout(16'($urandom_range(2, 6)));
      tick_rate_pct = 20;
      send_random_frames(6);
      set_timeout(16'($urandom_range(7, 30)));
      tick_rate_pct = 10;
      send_random_frames(6);
   endtask

   // Bodies around the limit: 195 completes, longer ones abort on the byte
   // that reaches it, including the last data byte
   task automatic test_overflow();
      logic [7:0] lens[5];
      set_timeout(16'($urandom_range(1024, 65534)));
      tick_rate_pct = 1;
      lens = '{8'd195, 8'd196, 8'd197, 8'd198, 8'($urandom_range(199, 255))};
      foreach (lens[k])
         send_frame(CMD_STATUS, lens[k], VAL_PRINTED, 0, 1'b1);
   endtask

   // Longer timeout: hold a frame open for exactly the limit, abort on the
   // next tick
   task automatic test_long_timeout();
      set_timeout(16'd40);
      idling_on     = 1'b0;
      tick_rate_pct = 0;
      send_rx(BYTE_HEAD0);
      send_rx(BYTE_HEAD1);
      repeat (40) send_tick();
      send_tick();
      idling_on = 1'b1;
   endtask

   // Last stretch at the reset timeout, with no idling on either side
   task automatic test_final_calm();
      idling_on = 1'b0;
      set_timeout(TIMEOUT_RESET);
      tick_rate_pct = 5;
      send_random_frames(8);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_frames();
      test_timeout_edges();
      test_random_frames();
      test_overflow();
      test_long_timeout();
      test_final_calm();
      // drain every outstanding response, then allow a few spare cycles
      req_valid <= 1'b0;
      while (frame_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Response side
   // -------------------------------------------------------------------------

   // Stall the response channel in random bursts while idling is on
   always @(posedge clock) begin
      if (rsp_stall_left != 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_ready      <= 1'b0;
      end else if (idling_on && !reset && $urandom_range(0, 4) == 0) begin
         rsp_stall_left <= $urandom_range(1, 6) - 1;
         rsp_ready      <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare each accepted response with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (frame_reports.size() == 0) begin
            $error("response item with nothing expected: %h", rsp_data);
            error_count++;
         end else begin
            want = frame_reports.pop_front();
            if (rsp_data.frame_done !== want.frame_done) begin
               $error("frame_done: expected %0h, got %0h",
                      want.frame_done, rsp_data.frame_done);
               error_count++;
            end
            if (rsp_data.frame_cmd !== want.frame_cmd) begin
               $error("frame_cmd: expected %0h, got %0h",
                      want.frame_cmd, rsp_data.frame_cmd);
               error_count++;
            end
            if (rsp_data.frame_value !== want.frame_value) begin
               $error("frame_value: expected %0h, got %0h",
                      want.frame_value, rsp_data.frame_value);
               error_count++;
            end
            if (rsp_data.status_event !== want.status_event) begin
               $error("status_event: expected %0h, got %0h",
                      want.status_event, rsp_data.status_event);
               error_count++;
            end
            if (rsp_data.abort_code !== want.abort_code) begin
               $error("abort_code: expected %0h, got %0h",
                      want.abort_code, rsp_data.abort_code);
               error_count++;
            end
         end
      end
   end

   // Drop out if no channel moves an item for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

endmodule
